@@ rtl/core/wdt_pkg.sv @@
// wdt_pkg: shared types and constants of the watchdog register block
// no dependencies; imported by wdt_state, watchdog_timer_registers and tb_top

package wdt_pkg;

	// width of the live count and reload registers
	localparam int unsigned COUNT_BITS = 32;

	localparam int unsigned DATA_BITS  = 32;
	localparam int unsigned CTL_BITS   = 4;
	localparam int unsigned WIDTH_BITS = 8;
	localparam int unsigned PULSE_BITS = WIDTH_BITS + 1;

	// item operation codes
	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2
	} wdt_op_t;

	// register word indexes
	localparam logic [2:0] REG_STATUS  = 3'd0;
	localparam logic [2:0] REG_RELOAD  = 3'd1;
	localparam logic [2:0] REG_RESTART = 3'd2;
	localparam logic [2:0] REG_CONTROL = 3'd3;
	localparam logic [2:0] REG_TIMEOUT = 3'd4;
	localparam logic [2:0] REG_CLEAR   = 3'd5;
	localparam logic [2:0] REG_WIDTH   = 3'd6;

	// restart key
	localparam logic [DATA_BITS-1:0] MAGIC_RESTART = 32'h0000_4755;

	// control bit positions
	localparam int unsigned CTL_EN  = 0;
	localparam int unsigned CTL_RST = 1;
	localparam int unsigned CTL_INT = 2;
	localparam int unsigned CTL_EXT = 3;

	// one input item
	typedef struct packed {
		logic [1:0]           opcode;
		logic [2:0]           reg_index;
		logic [DATA_BITS-1:0] write_data;
	} wdt_item_t;

	// one result item
	typedef struct packed {
		logic [DATA_BITS-1:0] read_data;
		logic                 irq_out;
		logic                 reset_out;
		logic                 ext_out;
	} wdt_result_t;

endpackage

@@ rtl/core/wdt_state.sv @@
// wdt_state: watchdog register file, down-counter and output pulse timer
// depends on wdt_pkg; applies one item per cycle when step is high

module wdt_state import wdt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  wdt_item_t   item,
	output wdt_result_t result
);

	logic [COUNT_BITS-1:0] count_q, count_d;
	logic [COUNT_BITS-1:0] reload_q, reload_d;
	logic [CTL_BITS-1:0]   ctl_q, ctl_d;
	logic                  flag_q, flag_d;
	logic [WIDTH_BITS-1:0] width_q, width_d;
	logic [PULSE_BITS-1:0] pulse_q, pulse_d;
	logic [DATA_BITS-1:0]  rd;

	// next state for the current item
	always_comb begin
		count_d  = count_q;
		reload_d = reload_q;
		ctl_d    = ctl_q;
		flag_d   = flag_q;
		width_d  = width_q;
		pulse_d  = pulse_q;
		rd       = '0;
		case (item.opcode)
			OP_TICK: begin
				// running pulse counts down on every tick
				if (pulse_q != '0) begin
					pulse_d = pulse_q - PULSE_BITS'(1);
				end
				if (ctl_q[CTL_EN]) begin
					if (count_q == '0) begin
						// underflow: flag, reload, retrigger pulse when reset or external output is on
						flag_d  = 1'b1;
						count_d = reload_q;
						if (ctl_q[CTL_RST] || ctl_q[CTL_EXT]) begin
							pulse_d = {1'b0, width_q} + PULSE_BITS'(1);
						end
					end else begin
						count_d = count_q - COUNT_BITS'(1);
					end
				end
			end
			OP_WRITE: begin
				unique case (item.reg_index)
					REG_RELOAD:  reload_d = item.write_data[COUNT_BITS-1:0];
					REG_RESTART: begin
						if (item.write_data == MAGIC_RESTART) begin
							count_d = reload_q;
						end
					end
					REG_CONTROL: ctl_d = item.write_data[CTL_BITS-1:0];
					REG_CLEAR: begin
						if (item.write_data[0]) begin
							flag_d = 1'b0;
						end
					end
					REG_WIDTH:   width_d = item.write_data[WIDTH_BITS-1:0];
					default: ;
				endcase
			end
			OP_READ: begin
				unique case (item.reg_index)
					REG_STATUS:  rd = DATA_BITS'(count_q);
					REG_RELOAD:  rd = DATA_BITS'(reload_q);
					REG_CONTROL: rd = DATA_BITS'(ctl_q);
					REG_TIMEOUT: rd = DATA_BITS'(flag_q);
					REG_WIDTH:   rd = DATA_BITS'(width_q);
					default:     rd = '0;
				endcase
			end
			default: ;
		endcase
	end

	// outputs follow the state after this item
	always_comb begin
		result.read_data = rd;
		result.irq_out   = flag_d && ctl_d[CTL_INT];
		result.reset_out = (pulse_d != '0) && ctl_d[CTL_RST];
		result.ext_out   = (pulse_d != '0) && ctl_d[CTL_EXT];
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '1;
			reload_q <= '1;
			ctl_q    <= '0;
			flag_q   <= 1'b0;
			width_q  <= '0;
			pulse_q  <= '0;
		end else if (step) begin
			count_q  <= count_d;
			reload_q <= reload_d;
			ctl_q    <= ctl_d;
			flag_q   <= flag_d;
			width_q  <= width_d;
			pulse_q  <= pulse_d;
		end
	end

endmodule

@@ rtl/core/watchdog_timer_registers.sv @@
// watchdog_timer_registers: top level of the watchdog register block
// depends on wdt_pkg and wdt_state
//
// Each transfer in is a timer tick, a register write or a register read, and
// gives exactly one transfer out carrying read data and the irq, reset and
// external output levels after that item. Items pass an input register, then
// the combinational update in wdt_state into the result register. One item
// per cycle is sustained while out_stall is low, since the counter and pulse
// state are computed combinationally. in_stall rises only when the input
// register and the result register are both full and out_stall is high.

module watchdog_timer_registers import wdt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            opcode,
	input  logic [2:0]            reg_index,
	input  logic [DATA_BITS-1:0]  write_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [DATA_BITS-1:0]  read_data,
	output logic                  irq_out,
	output logic                  reset_out,
	output logic                  ext_out
);

	logic        valid_s1;
	wdt_item_t   item_s1;
	logic        out_valid_q;
	wdt_result_t result_q;
	wdt_result_t result;
	logic        advance;
	logic        in_take;

	// stage 1 moves on when the result register is free or drained
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= '{opcode: opcode, reg_index: reg_index, write_data: write_data};
		end
	end

	// register file and timers
	wdt_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.result (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = result_q.read_data;
	assign irq_out   = result_q.irq_out;
	assign reset_out = result_q.reset_out;
	assign ext_out   = result_q.ext_out;

endmodule

@@ dv/tb_top.sv @@
// tb_top: self-checking testbench of the watchdog register block
// depends on wdt_pkg and watchdog_timer_registers, nothing else
// directed register, restart and timeout tests, then weighted random traffic

module tb_top import wdt_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	// opcode and index the package leaves unnamed
	localparam logic [1:0] OP_UNUSED    = 2'd3;
	localparam logic [2:0] REG_UNMAPPED = 3'd7;

	localparam int unsigned CYCLE_LIMIT  = 500000;
	localparam int unsigned DRAIN_CYCLES = 8;

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 in_valid   = 1'b0;
	logic                 in_stall;
	logic [1:0]           opcode     = OP_TICK;
	logic [2:0]           reg_index  = REG_STATUS;
	logic [DATA_BITS-1:0] write_data = '0;
	logic                 out_valid;
	logic                 out_stall  = 1'b0;
	logic [DATA_BITS-1:0] read_data;
	logic                 irq_out;
	logic                 reset_out;
	logic                 ext_out;

	// watchdog state as the testbench tracks it
	logic [COUNT_BITS-1:0] wd_count;
	logic [COUNT_BITS-1:0] wd_reload;
	logic [CTL_BITS-1:0]   wd_ctrl;
	logic                  wd_flag;
	logic [WIDTH_BITS-1:0] wd_width;
	logic [PULSE_BITS-1:0] wd_pulse_left;

	wdt_result_t pending_outputs[$];
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;
	int unsigned stall_left  = 0;
	bit          idle_on     = 1'b1;

	watchdog_timer_registers dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.reg_index  (reg_index),
		.write_data (write_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_data  (read_data),
		.irq_out    (irq_out),
		.reset_out  (reset_out),
		.ext_out    (ext_out)
	);

	// 100 MHz clock
	initial begin
		forever #5 clk = ~clk;
	end

	// apply one item to the tracked state and return the levels after it
	function automatic wdt_result_t step_watchdog(logic [1:0] op, logic [2:0] idx,
			logic [DATA_BITS-1:0] data);
		wdt_result_t res;
		logic        active;
		res = '0;
		case (op)
			OP_TICK: begin
				// pulse runs down on every tick, enabled or not
				if (wd_pulse_left != 0)
					wd_pulse_left = wd_pulse_left - 1'b1;
				if (wd_ctrl[CTL_EN]) begin
					if (wd_count == 0) begin
						wd_flag  = 1'b1;
						wd_count = wd_reload;
						if (wd_ctrl[CTL_RST] || wd_ctrl[CTL_EXT])
							wd_pulse_left = {1'b0, wd_width} + 1'b1;
					end else begin
						wd_count = wd_count - 1'b1;
					end
				end
			end
			OP_WRITE: begin
				case (idx)
					REG_RELOAD:  wd_reload = data[COUNT_BITS-1:0];
					REG_RESTART: if (data == MAGIC_RESTART) wd_count = wd_reload;
					REG_CONTROL: wd_ctrl = data[CTL_BITS-1:0];
					REG_CLEAR:   if (data[0]) wd_flag = 1'b0;
					REG_WIDTH:   wd_width = data[WIDTH_BITS-1:0];
					default:     ;
				endcase
			end
			OP_READ: begin
				case (idx)
					REG_STATUS:  res.read_data = DATA_BITS'(wd_count);
					REG_RELOAD:  res.read_data = DATA_BITS'(wd_reload);
					REG_CONTROL: res.read_data = DATA_BITS'(wd_ctrl);
					REG_TIMEOUT: res.read_data = DATA_BITS'(wd_flag);
					REG_WIDTH:   res.read_data = DATA_BITS'(wd_width);
					default:     res.read_data = '0;
				endcase
			end
			default: ;
		endcase
		active        = (wd_pulse_left != 0);
		res.irq_out   = wd_flag & wd_ctrl[CTL_INT];
		res.reset_out = active & wd_ctrl[CTL_RST];
		res.ext_out   = active & wd_ctrl[CTL_EXT];
		return res;
	endfunction

	// idle length: mostly none, some short, a few long
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(3, 1);
		else
			return $urandom_range(24, 4);
	endfunction

	function automatic void check_field(string field, logic [DATA_BITS-1:0] expected_val,
			logic [DATA_BITS-1:0] actual_val);
		if (actual_val !== expected_val) begin
			$display("%0t: %s mismatch, expected %h, actual %h",
				$time, field, expected_val, actual_val);
			error_count++;
		end
	endfunction

	// one input transfer, then an optional gap; called right after a rising edge
	task automatic send_item(input logic [1:0] op, input logic [2:0] idx,
			input logic [DATA_BITS-1:0] data);
		int unsigned gap;
		opcode     <= op;
		reg_index  <= idx;
		write_data <= data;
		in_valid   <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_outputs.push_back(step_watchdog(op, idx, data));
		gap = idle_on ? pick_gap() : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// reset values of every readable register
	task automatic test_reset_values();
		send_item(OP_READ, REG_STATUS, '0);
		send_item(OP_READ, REG_RELOAD, '0);
		send_item(OP_READ, REG_CONTROL, '0);
		send_item(OP_READ, REG_TIMEOUT, '0);
		send_item(OP_READ, REG_WIDTH, '0);
	endtask

	// wide data truncation, ignored writes, zero reads, unused opcode
	task automatic test_register_access();
		send_item(OP_WRITE, REG_RELOAD, 32'h0000_0000);
		send_item(OP_WRITE, REG_CONTROL, 32'hFFFF_FFF0);
		send_item(OP_WRITE, REG_WIDTH, 32'hFFFF_FF01);
		send_item(OP_WRITE, REG_STATUS, 32'hFFFF_FFFF);
		send_item(OP_WRITE, REG_TIMEOUT, 32'hFFFF_FFFF);
		send_item(OP_WRITE, REG_UNMAPPED, 32'hFFFF_FFFF);
		send_item(OP_READ, REG_RESTART, '0);
		send_item(OP_READ, REG_CLEAR, '0);
		send_item(OP_READ, REG_UNMAPPED, '0);
		send_item(OP_UNUSED, REG_RELOAD, 32'hFFFF_FFFF);
	endtask

	// restart key, underflow with zero reload, retrigger, counter off, flag clear
	task automatic test_restart_and_timeout();
		send_item(OP_WRITE, REG_RESTART, MAGIC_RESTART ^ 32'h1);
		send_item(OP_WRITE, REG_RESTART, MAGIC_RESTART);
		send_item(OP_WRITE, REG_CONTROL, 32'h0000_000F);
		send_item(OP_TICK, REG_STATUS, '0);
		send_item(OP_TICK, REG_STATUS, '0);
		send_item(OP_WRITE, REG_CONTROL, 32'h0000_000A);
		send_item(OP_TICK, REG_STATUS, '0);
		send_item(OP_TICK, REG_STATUS, '0);
		send_item(OP_WRITE, REG_CLEAR, 32'hFFFF_FFFE);
		send_item(OP_WRITE, REG_CLEAR, 32'h0000_0001);
		send_item(OP_READ, REG_TIMEOUT, '0);
	endtask

	// weighted random items: mostly ticks, small reloads so underflows recur
	task automatic test_random_traffic(input int unsigned n_items);
		logic [1:0]           op;
		logic [2:0]           idx;
		logic [DATA_BITS-1:0] data;
		int unsigned          pick;
		for (int i = 0; i < n_items; i++) begin
			pick = $urandom_range(99);
			data = $urandom;
			idx  = 3'($urandom_range(7));
			if (pick < 55) begin
				op = OP_TICK;
			end else if (pick < 80) begin
				op = OP_WRITE;
				case (idx)
					REG_RELOAD:  if ($urandom_range(9) != 0) data = $urandom_range(12);
					REG_RESTART: if ($urandom_range(3) != 0) data = MAGIC_RESTART;
					REG_CONTROL: if ($urandom_range(3) != 0) data[CTL_EN] = 1'b1;
					REG_WIDTH:   if ($urandom_range(7) != 0) data = $urandom_range(6);
					default:     ;
				endcase
			end else if (pick < 96) begin
				op = OP_READ;
			end else begin
				op = OP_UNUSED;
			end
			send_item(op, idx, data);
		end
	endtask

	// result side backpressure in bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (idle_on && $urandom_range(99) < 25) begin
			stall_left = pick_gap();
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// compare every result transfer with the oldest pending prediction
	always @(posedge clk) begin
		wdt_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_outputs.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual read_data %h",
					$time, read_data);
				error_count++;
			end else begin
				want = pending_outputs.pop_front();
				check_field("read_data", want.read_data, read_data);
				check_field("irq_out", DATA_BITS'(want.irq_out), DATA_BITS'(irq_out));
				check_field("reset_out", DATA_BITS'(want.reset_out), DATA_BITS'(reset_out));
				check_field("ext_out", DATA_BITS'(want.ext_out), DATA_BITS'(ext_out));
			end
		end
	end

	// run limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Verification failed");
		$finish;
	end

	// test sequence
	initial begin
		wd_count      = '1;
		wd_reload     = '1;
		wd_ctrl       = '0;
		wd_flag       = 1'b0;
		wd_width      = '0;
		wd_pulse_left = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_register_access();
		test_restart_and_timeout();
		test_random_traffic(300);
		idle_on = 1'b0;
		test_random_traffic(200);
		idle_on = 1'b1;
		test_random_traffic(300);

		// drain outstanding results with the outputs free
		in_valid <= 1'b0;
		idle_on = 1'b0;
		while (pending_outputs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
